@@ hdl/x86_mov_load_store_decoder_defines.svh @@
// Assertion macros used by the checker of the decoder.
`ifndef X86_MOV_LOAD_STORE_DECODER_DEFINES_SVH
`define X86_MOV_LOAD_STORE_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define XMLSD_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder check failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define XMLSD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder check failed");

`endif

@@ hdl/xmlsd_pkg.sv @@
package xmlsd_pkg;

    // Beat widths on the two streams.
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USER_W = 2;

    // Bit positions of the result fields inside the output tdata.
    localparam int LOAD_LSB   = 0;
    localparam int SWAP_LSB   = 1;
    localparam int IMMF_LSB   = 2;
    localparam int VAL_LSB    = 3;
    localparam int BASE_LSB   = 7;
    localparam int INDEX_LSB  = 11;
    localparam int SCALE_LSB  = 16;
    localparam int DISP_LSB   = 18;
    localparam int IMM_LSB    = 50;
    localparam int LEN_LSB    = 82;
    localparam int LEN_W      = 4;

    // Parse phases of the byte-serial decoder.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_FIRST,
        PH_OPCODE,
        PH_ESC38,
        PH_ESCOP,
        PH_MODRM,
        PH_SIB,
        PH_DISP,
        PH_IMM
    } phase_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK,
        ST_UNKNOWN_OP,
        ST_RIP_REL,
        ST_SIB_BASE
    } status_t;

    // Opcode and prefix bytes.
    localparam logic [7:0] REX_MASK      = 8'hF0;
    localparam logic [7:0] REX_CODE      = 8'h40;
    localparam logic [7:0] OP_ESCAPE     = 8'h0F;
    localparam logic [7:0] OP_ESC_38     = 8'h38;
    localparam logic [7:0] OP_MOVBE_ST   = 8'hF1;
    localparam logic [7:0] OP_MOVBE_LD   = 8'hF0;
    localparam logic [7:0] OP_MOV_ST     = 8'h89;
    localparam logic [7:0] OP_MOV_LD     = 8'h8B;
    localparam logic [7:0] OP_MOV_ST_IMM = 8'hC7;

    // ModRM and SIB field codes.
    localparam logic [2:0] RM_SIB     = 3'b100;
    localparam logic [2:0] RM_DISP32  = 3'b101;
    localparam logic [2:0] IDX_NONE   = 3'b100;
    localparam logic [1:0] MOD_NODISP = 2'b00;
    localparam logic [1:0] MOD_DISP8  = 2'b01;
    localparam logic [1:0] MOD_DISP32 = 2'b10;
    localparam logic [1:0] MOD_REG    = 2'b11;
    localparam logic [4:0] NO_INDEX   = 5'd16;

endpackage

@@ hdl/x86_mov_load_store_decoder.sv @@
// Channel   Dir  tdata (low bit up)                                    tuser
// s_axis    in   instruction_byte[7:0]                                 start_flag
// m_axis    out  is_load, swaps_bytes, has_immediate, value_register,  status[1:0]
//                base_register, index_register, scale_log2,
//                displacement, immediate, length, 2 zero bits
// One instruction byte is taken per cycle; a result appears in the cycle after the byte
// that completes or fails the instruction, held in a single output register.
// Input is stalled only while that register is full and m_axis_tready is low.
// rst_n clears the parse phase and the output valid asynchronously.
module x86_mov_load_store_decoder
    import xmlsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // instruction_byte
    input  logic                  s_axis_tuser,   // start_flag
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // is_load, swaps_bytes, has_immediate, value_register, base_register,
    // index_register, scale_log2, displacement, immediate, length, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [OUT_USER_W-1:0] m_axis_tuser    // status
);

    // Parse state.
    phase_t      phase_reg, phase_next;
    logic [3:0]  rex_reg, rex_next;
    logic [3:0]  count_reg, count_next;
    logic        load_reg, load_next;
    logic        swap_reg, swap_next;
    logic        immf_reg, immf_next;
    logic [3:0]  val_reg, val_next;
    logic [3:0]  base_reg, base_next;
    logic [4:0]  index_reg, index_next;
    logic [1:0]  scale_reg, scale_next;
    logic [1:0]  mod_reg, mod_next;
    logic [31:0] disp_reg, disp_next;
    logic [31:0] imm_reg, imm_next;
    logic [1:0]  fcnt_reg, fcnt_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    status_t               out_status_reg, out_status_next;

    // State as seen by the current byte: a start beat begins from a clean parse.
    phase_t      eph;
    logic [3:0]  e_rex, e_count, e_val, e_base;
    logic        e_load, e_swap, e_immf;
    logic [4:0]  e_index;
    logic [1:0]  e_scale, e_mod, e_fcnt;
    logic [31:0] e_disp, e_imm;

    logic        in_fire;
    logic [7:0]  in_byte;
    logic        is_rex;
    logic        op_known;
    logic [1:0]  b_mod;
    logic [2:0]  b_reg, b_rm;
    logic        emit;
    status_t     res_status;
    logic [3:0]  sib_idx_ext;

    // Phase after the address bytes: displacement, immediate or done.
    function automatic phase_t after_address(input logic [1:0] m, input logic immf);
        phase_t p;
        if (m == MOD_DISP8 || m == MOD_DISP32)
        begin
            p = PH_DISP;
        end
        else if (immf)
        begin
            p = PH_IMM;
        end
        else
        begin
            p = PH_IDLE;
        end
        return p;
    endfunction

    assign in_byte       = s_axis_tdata;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Byte fields used by several phases.
    assign is_rex      = (in_byte & REX_MASK) == REX_CODE;
    assign op_known    = (in_byte == OP_ESCAPE) || (in_byte == OP_MOV_ST) ||
                         (in_byte == OP_MOV_LD) || (in_byte == OP_MOV_ST_IMM);
    assign b_mod       = in_byte[7:6];
    assign b_reg       = in_byte[5:3];
    assign b_rm        = in_byte[2:0];
    assign sib_idx_ext = {e_rex[1], b_reg};

    // Effective state for this beat.
    always_comb
    begin
        if (s_axis_tuser)
        begin
            eph     = PH_FIRST;
            e_rex   = '0;
            e_count = '0;
            e_load  = 1'b0;
            e_swap  = 1'b0;
            e_immf  = 1'b0;
            e_val   = '0;
            e_base  = '0;
            e_index = '0;
            e_scale = '0;
            e_mod   = '0;
            e_disp  = '0;
            e_imm   = '0;
            e_fcnt  = '0;
        end
        else
        begin
            eph     = phase_reg;
            e_rex   = rex_reg;
            e_count = count_reg;
            e_load  = load_reg;
            e_swap  = swap_reg;
            e_immf  = immf_reg;
            e_val   = val_reg;
            e_base  = base_reg;
            e_index = index_reg;
            e_scale = scale_reg;
            e_mod   = mod_reg;
            e_disp  = disp_reg;
            e_imm   = imm_reg;
            e_fcnt  = fcnt_reg;
        end
    end

    // Next parse state.
    always_comb
    begin
        phase_next = eph;
        rex_next   = e_rex;
        count_next = (eph == PH_IDLE) ? e_count : e_count + 4'd1;
        load_next  = e_load;
        swap_next  = e_swap;
        immf_next  = e_immf;
        val_next   = e_val;
        base_next  = e_base;
        index_next = e_index;
        scale_next = e_scale;
        mod_next   = e_mod;
        disp_next  = e_disp;
        imm_next   = e_imm;
        fcnt_next  = e_fcnt;
        unique case (eph)
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            PH_FIRST, PH_OPCODE:
            begin
                if (eph == PH_FIRST && is_rex)
                begin
                    rex_next   = in_byte[3:0];
                    phase_next = PH_OPCODE;
                end
                else if (in_byte == OP_ESCAPE)
                begin
                    phase_next = PH_ESC38;
                end
                else if (in_byte == OP_MOV_ST)
                begin
                    phase_next = PH_MODRM;
                end
                else if (in_byte == OP_MOV_LD)
                begin
                    load_next  = 1'b1;
                    phase_next = PH_MODRM;
                end
                else if (in_byte == OP_MOV_ST_IMM)
                begin
                    immf_next  = 1'b1;
                    phase_next = PH_MODRM;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_ESC38:
            begin
                phase_next = (in_byte == OP_ESC_38) ? PH_ESCOP : PH_IDLE;
            end
            PH_ESCOP:
            begin
                if (in_byte == OP_MOVBE_ST)
                begin
                    swap_next  = 1'b1;
                    phase_next = PH_MODRM;
                end
                else if (in_byte == OP_MOVBE_LD)
                begin
                    swap_next  = 1'b1;
                    load_next  = 1'b1;
                    phase_next = PH_MODRM;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_MODRM:
            begin
                mod_next   = b_mod;
                val_next   = {e_rex[2], b_reg};
                index_next = NO_INDEX;
                scale_next = '0;
                if (b_rm == RM_SIB)
                begin
                    phase_next = PH_SIB;
                end
                else if (b_rm == RM_DISP32 && b_mod == MOD_NODISP)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    base_next  = {e_rex[0], b_rm};
                    phase_next = after_address(b_mod, e_immf);
                end
            end
            PH_SIB:
            begin
                if (b_rm == RM_DISP32)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    scale_next = b_mod;
                    index_next = (sib_idx_ext == {1'b0, IDX_NONE}) ? NO_INDEX
                                                                   : {1'b0, sib_idx_ext};
                    base_next  = {e_rex[0], b_rm};
                    phase_next = after_address(e_mod, e_immf);
                end
            end
            PH_DISP:
            begin
                if (e_mod == MOD_DISP8)
                begin
                    disp_next  = {{24{in_byte[7]}}, in_byte};
                    phase_next = e_immf ? PH_IMM : PH_IDLE;
                end
                else
                begin
                    disp_next[{e_fcnt, 3'b000} +: 8] = e_disp[{e_fcnt, 3'b000} +: 8] | in_byte;
                    if (e_fcnt == 2'd3)
                    begin
                        fcnt_next  = '0;
                        phase_next = e_immf ? PH_IMM : PH_IDLE;
                    end
                    else
                    begin
                        fcnt_next = e_fcnt + 2'd1;
                    end
                end
            end
            PH_IMM:
            begin
                imm_next[{e_fcnt, 3'b000} +: 8] = e_imm[{e_fcnt, 3'b000} +: 8] | in_byte;
                if (e_fcnt == 2'd3)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    fcnt_next = e_fcnt + 2'd1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Result decision for this beat.
    always_comb
    begin
        emit       = 1'b0;
        res_status = ST_OK;
        unique case (eph)
            PH_FIRST, PH_OPCODE:
            begin
                if (!(eph == PH_FIRST && is_rex) && !op_known)
                begin
                    emit       = 1'b1;
                    res_status = ST_UNKNOWN_OP;
                end
            end
            PH_ESC38:
            begin
                if (in_byte != OP_ESC_38)
                begin
                    emit       = 1'b1;
                    res_status = ST_UNKNOWN_OP;
                end
            end
            PH_ESCOP:
            begin
                if (in_byte != OP_MOVBE_ST && in_byte != OP_MOVBE_LD)
                begin
                    emit       = 1'b1;
                    res_status = ST_UNKNOWN_OP;
                end
            end
            PH_MODRM:
            begin
                if (b_rm == RM_DISP32 && b_mod == MOD_NODISP)
                begin
                    emit       = 1'b1;
                    res_status = ST_RIP_REL;
                end
                else if (b_rm != RM_SIB && !e_immf &&
                         (b_mod == MOD_NODISP || b_mod == MOD_REG))
                begin
                    emit = 1'b1;
                end
            end
            PH_SIB:
            begin
                if (b_rm == RM_DISP32)
                begin
                    emit       = 1'b1;
                    res_status = ST_SIB_BASE;
                end
                else if (!e_immf && (e_mod == MOD_NODISP || e_mod == MOD_REG))
                begin
                    emit = 1'b1;
                end
            end
            PH_DISP:
            begin
                emit = !e_immf && (e_mod == MOD_DISP8 || e_fcnt == 2'd3);
            end
            PH_IMM:
            begin
                emit = (e_fcnt == 2'd3);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Output beat: packed fields on success, all zero on failure.
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        if (in_fire && emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status;
            out_data_next   = '0;
            if (res_status == ST_OK)
            begin
                out_data_next[LOAD_LSB]            = load_next;
                out_data_next[SWAP_LSB]            = swap_next;
                out_data_next[IMMF_LSB]            = immf_next;
                out_data_next[VAL_LSB +: 4]        = val_next;
                out_data_next[BASE_LSB +: 4]       = base_next;
                out_data_next[INDEX_LSB +: 5]      = index_next;
                out_data_next[SCALE_LSB +: 2]      = scale_next;
                out_data_next[DISP_LSB +: 32]      = disp_next;
                out_data_next[IMM_LSB +: 32]       = imm_next;
                out_data_next[LEN_LSB +: LEN_W]    = count_next;
            end
        end
    end

    // Parse state registers, updated on each accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            rex_reg   <= '0;
            count_reg <= '0;
            load_reg  <= 1'b0;
            swap_reg  <= 1'b0;
            immf_reg  <= 1'b0;
            val_reg   <= '0;
            base_reg  <= '0;
            index_reg <= '0;
            scale_reg <= '0;
            mod_reg   <= '0;
            disp_reg  <= '0;
            imm_reg   <= '0;
            fcnt_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            rex_reg   <= rex_next;
            count_reg <= count_next;
            load_reg  <= load_next;
            swap_reg  <= swap_next;
            immf_reg  <= immf_next;
            val_reg   <= val_next;
            base_reg  <= base_next;
            index_reg <= index_next;
            scale_reg <= scale_next;
            mod_reg   <= mod_next;
            disp_reg  <= disp_next;
            imm_reg   <= imm_next;
            fcnt_reg  <= fcnt_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

@@ hdl/xmlsd_checker.sv @@
`include "x86_mov_load_store_decoder_defines.svh"

module xmlsd_checker
    import xmlsd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic                  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser
);

    logic fail_beat;
    logic ok_beat;

    assign fail_beat = m_axis_tvalid && (m_axis_tuser != ST_OK);
    assign ok_beat   = m_axis_tvalid && (m_axis_tuser == ST_OK);

    // A failed instruction reports no length.
    `XMLSD_ASSERT_NOW(a_fail_len_zero, fail_beat, m_axis_tdata[LEN_LSB +: LEN_W] == '0)

    // A decoded instruction holds at least an opcode and a ModRM byte.
    `XMLSD_ASSERT_NOW(a_ok_len_min, ok_beat, m_axis_tdata[LEN_LSB +: LEN_W] >= 4'd2)

    // An immediate store never loads.
    `XMLSD_ASSERT_NOW(a_imm_not_load, ok_beat && m_axis_tdata[IMMF_LSB], !m_axis_tdata[LOAD_LSB])

    // With the output register empty, input is always taken.
    `XMLSD_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

    // A stalled result beat stays put.
    `XMLSD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind x86_mov_load_store_decoder xmlsd_checker u_xmlsd_checker (.*);
